// ===== rtl/core/rpr_pkg.sv =====
// Shared constants, register codes and control structs for the polyphase
// rational resampler. Depends on nothing; every other RTL file imports it.
`default_nettype none

package rpr_pkg;

   localparam int COEF_DEPTH    = 256;
   localparam int HISTORY_DEPTH = 64;
   localparam int MAX_INTERP    = 8;
   localparam int SAMPLE_WIDTH  = 24;

   // fixed field widths
   localparam int OP_W       = 2;
   localparam int COEF_IDX_W = 8;
   localparam int COEF_W     = 20;
   localparam int FACTOR_W   = 4;
   localparam int FLEN_W     = 9;
   localparam int BOUND_W    = 24;
   localparam int SPAN_W     = 23;
   localparam int PHASE_W    = 3;
   localparam int FRAC_BITS  = 14;

   // derived widths
   localparam int CA_W    = $clog2(COEF_DEPTH);
   localparam int HA_W    = $clog2(HISTORY_DEPTH);
   localparam int DEPTH_W = $clog2(HISTORY_DEPTH + 1);
   localparam int LEN_W   = $clog2(COEF_DEPTH + 1);
   localparam int TAP_W   = LEN_W + 1;
   localparam int L_W     = $clog2(MAX_INTERP + 1);
   localparam int CNT_W   = $clog2(LEN_W + 1);
   localparam int ADJ_W   = ((SAMPLE_WIDTH > BOUND_W) ? SAMPLE_WIDTH : BOUND_W) + 1;
   localparam int PROD_W  = COEF_W + ADJ_W;
   localparam int ACC_W   = PROD_W + CA_W + 1;

   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1 << (FRAC_BITS - 1));
   localparam logic signed [ACC_W-1:0] SAT_MAX    = ACC_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
   localparam logic signed [ACC_W-1:0] SAT_MIN    = ~SAT_MAX;

   localparam logic [FACTOR_W-1:0] DECIM_RESET = FACTOR_W'(1);

   // APB
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int REG_IDX_W = 3;

   localparam logic [REG_IDX_W-1:0] REG_INTERP      = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_DECIM       = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_FLEN        = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_UNWRAP_EN   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_UNWRAP_LOW  = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_UNWRAP_HIGH = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_UNWRAP_SPAN = 3'd6;

   // transaction opcodes
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
   localparam logic [OP_W-1:0] OP_COEF   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // effective configuration, already clamped
   typedef struct packed {
      logic [L_W-1:0]      interp;
      logic [FACTOR_W-1:0] decim;
      logic [LEN_W-1:0]    len;
      logic                unwrap_en;
      logic [BOUND_W-1:0]  low;
      logic [BOUND_W-1:0]  high;
      logic [SPAN_W-1:0]   span;
   } cfg_type;

   typedef struct packed {
      logic                    coef_we;
      logic [CA_W-1:0]         coef_waddr;
      logic [COEF_W-1:0]       coef_wdata;
      logic                    hist_we;
      logic                    hist_clear;
      logic [HA_W-1:0]         hist_waddr;
      logic [SAMPLE_WIDTH-1:0] hist_wdata;
      logic                    rd_en;
      logic                    rd_mac;
      logic [HA_W-1:0]         rd_hist_addr;
      logic [CA_W-1:0]         rd_coef_addr;
      logic                    flag_clear;
      logic                    acc_clear;
      logic                    fix;
   } dp_ctl_type;

   typedef struct packed {
      logic             busy;
      logic             lo;
      logic             hi;
      logic [ACC_W-1:0] acc;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== rtl/core/rpr_if.sv =====
// Valid/ready channel interfaces for the resampler request and response.
// Depends on rpr_pkg.
`default_nettype none

interface rpr_req_if import rpr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         op;
   logic [COEF_IDX_W-1:0]   coef_index;
   logic [COEF_W-1:0]       coef_value;
   logic [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, op, coef_index, coef_value, sample_in, input ready);
   modport sink   (input valid, op, coef_index, coef_value, sample_in, output ready);
endinterface

interface rpr_rsp_if import rpr_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [SAMPLE_WIDTH-1:0] sample_out;
   logic [PHASE_W-1:0]      phase;
   logic                    last;

   modport source (output valid, sample_out, phase, last, input ready);
   modport sink   (input valid, sample_out, phase, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rpr_csr.sv =====
// APB register file of the resampler; also clamps factors and length.
// Depends on rpr_pkg.
`default_nettype none

module rpr_csr import rpr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [FACTOR_W-1:0] interp_ff;
   logic [FACTOR_W-1:0] decim_ff;
   logic [FLEN_W-1:0]   flen_ff;
   logic                uen_ff;
   logic [BOUND_W-1:0]  low_ff;
   logic [BOUND_W-1:0]  high_ff;
   logic [SPAN_W-1:0]   span_ff;
   logic [REG_IDX_W-1:0] idx;
   logic                 wr;

   assign idx    = paddr[ADDR_W-1:2];
   assign wr     = psel & penable & pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         interp_ff <= FACTOR_W'(1);
         decim_ff  <= FACTOR_W'(1);
         flen_ff   <= FLEN_W'(1);
         uen_ff    <= 1'b0;
         low_ff    <= '0;
         high_ff   <= '0;
         span_ff   <= '0;
      end else if (wr) begin
         unique case (idx)
            REG_INTERP:      interp_ff <= pwdata[FACTOR_W-1:0];
            REG_DECIM:       decim_ff  <= pwdata[FACTOR_W-1:0];
            REG_FLEN:        flen_ff   <= pwdata[FLEN_W-1:0];
            REG_UNWRAP_EN:   uen_ff    <= pwdata[0];
            REG_UNWRAP_LOW:  low_ff    <= pwdata[BOUND_W-1:0];
            REG_UNWRAP_HIGH: high_ff   <= pwdata[BOUND_W-1:0];
            REG_UNWRAP_SPAN: span_ff   <= pwdata[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_INTERP:      prdata = DATA_W'(interp_ff);
         REG_DECIM:       prdata = DATA_W'(decim_ff);
         REG_FLEN:        prdata = DATA_W'(flen_ff);
         REG_UNWRAP_EN:   prdata = DATA_W'(uen_ff);
         REG_UNWRAP_LOW:  prdata = DATA_W'(low_ff);
         REG_UNWRAP_HIGH: prdata = DATA_W'(high_ff);
         REG_UNWRAP_SPAN: prdata = DATA_W'(span_ff);
         default:         prdata = '0;
      endcase
   end

   // zero factors act as one, oversize values clamp to the hardware limits
   always_comb begin
      if (interp_ff == '0)
         cfg.interp = L_W'(1);
      else if (32'(interp_ff) > MAX_INTERP)
         cfg.interp = L_W'(MAX_INTERP);
      else
         cfg.interp = L_W'(interp_ff);

      cfg.decim = (decim_ff == '0) ? FACTOR_W'(1) : decim_ff;

      if (flen_ff == '0)
         cfg.len = LEN_W'(1);
      else if (32'(flen_ff) > COEF_DEPTH)
         cfg.len = LEN_W'(COEF_DEPTH);
      else
         cfg.len = LEN_W'(flen_ff);

      cfg.unwrap_en = uen_ff;
      cfg.low       = low_ff;
      cfg.high      = high_ff;
      cfg.span      = span_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/core/rpr_datapath.sv =====
// Coefficient and history memories plus the shared unwrap-compare and
// multiply-accumulate pipeline. Depends on rpr_pkg.
`default_nettype none

module rpr_datapath import rpr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  dp_ctl_type ctl,
   input  cfg_type    cfg,
   output dp_sts_type sts
);

   logic [SAMPLE_WIDTH-1:0] hist_mem [HISTORY_DEPTH];
   logic [COEF_W-1:0]       coef_mem [COEF_DEPTH];
   logic [HISTORY_DEPTH-1:0] hv_ff;

   logic [SAMPLE_WIDTH-1:0] hist_q_ff;
   logic [COEF_W-1:0]       coef_q_ff;
   logic                    hvq_ff;
   logic                    v1_ff, mac1_ff;
   logic [ADJ_W-1:0]        adj_ff;
   logic [COEF_W-1:0]       coef2_ff;
   logic                    v2_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic                    v3_ff;
   logic [ACC_W-1:0]        acc_ff;
   logic                    lo_ff, hi_ff;

   logic [ADJ_W-1:0] samp, low_x, high_x, span_x, adj_in;
   logic             is_lo, is_hi;

   always_ff @(posedge clock) begin
      if (ctl.hist_we)
         hist_mem[ctl.hist_waddr] <= ctl.hist_wdata;
      if (ctl.coef_we)
         coef_mem[ctl.coef_waddr] <= ctl.coef_wdata;
      hist_q_ff <= hist_mem[ctl.rd_hist_addr];
      coef_q_ff <= coef_mem[ctl.rd_coef_addr];
      hvq_ff    <= hv_ff[ctl.rd_hist_addr];
   end

   // history entries read as zero until written after reset or clear
   always_ff @(posedge clock) begin
      if (reset || ctl.hist_clear)
         hv_ff <= '0;
      else if (ctl.hist_we)
         hv_ff[ctl.hist_waddr] <= 1'b1;
   end

   always_comb begin
      samp   = hvq_ff ? {{(ADJ_W-SAMPLE_WIDTH){hist_q_ff[SAMPLE_WIDTH-1]}}, hist_q_ff} : '0;
      low_x  = {{(ADJ_W-BOUND_W){cfg.low[BOUND_W-1]}}, cfg.low};
      high_x = {{(ADJ_W-BOUND_W){cfg.high[BOUND_W-1]}}, cfg.high};
      span_x = ADJ_W'(cfg.span);
      is_lo  = $signed(samp) < $signed(low_x);
      is_hi  = $signed(samp) > $signed(high_x);
      adj_in = (ctl.fix && is_lo) ? samp + span_x : samp;
   end

   always_ff @(posedge clock) begin
      adj_ff   <= adj_in;
      coef2_ff <= coef_q_ff;
      prod_ff  <= PROD_W'($signed(coef2_ff) * $signed(adj_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         mac1_ff <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         lo_ff   <= 1'b0;
         hi_ff   <= 1'b0;
         acc_ff  <= '0;
      end else begin
         v1_ff   <= ctl.rd_en;
         mac1_ff <= ctl.rd_mac;
         v2_ff   <= v1_ff & mac1_ff;
         v3_ff   <= v2_ff;
         if (ctl.flag_clear) begin
            lo_ff <= 1'b0;
            hi_ff <= 1'b0;
         end else if (v1_ff && !mac1_ff) begin
            lo_ff <= lo_ff | is_lo;
            hi_ff <= hi_ff | is_hi;
         end
         if (ctl.acc_clear)
            acc_ff <= '0;
         else if (v3_ff)
            acc_ff <= acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end
   end

   assign sts.busy = v1_ff | v2_ff | v3_ff;
   assign sts.lo   = lo_ff;
   assign sts.hi   = hi_ff;
   assign sts.acc  = acc_ff;

endmodule

`default_nettype wire

// ===== rtl/core/polyphase_rational_resampler.sv =====
// Top level of the polyphase rational resampler: sequencer, output register.
// Depends on rpr_pkg, rpr_if, rpr_csr and rpr_datapath.
//
// Usage: req_ch carries transactions: load coefficient, clear filter state,
// or sample. Load coefficients first, then stream samples. Each sample steps
// through L sub-phases; every M-th sub-phase yields one response on rsp_ch,
// with last set on the final response of that sample. Registers must be
// written through the APB port while the block is idle; the block itself
// does not enforce this. Sequence: load and clear finish on acceptance. A
// sample first runs a restoring division, one step per length bit, for the
// clamped history depth, then writes history; each of its R responses
// walks its T taps through the single shared multiply-accumulate pipe
// (and first through the compare path when unwrap is enabled).
// req_ch.ready is high only between samples. A response sits in the output
// register until taken; a stalled receiver holds the sequencer at the next
// response, while the final response may wait as the next request enters.
// Reset (synchronous) clears history, pointers and registers.
`default_nettype none

module polyphase_rational_resampler import rpr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   rpr_req_if.sink           req_ch,
   rpr_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_DIV       = 9'b000000010,
      ST_WRITE     = 9'b000000100,
      ST_PHASE     = 9'b000001000,
      ST_SCAN      = 9'b000010000,
      ST_SCAN_WAIT = 9'b000100000,
      ST_MAC       = 9'b001000000,
      ST_MAC_WAIT  = 9'b010000000,
      ST_OUT       = 9'b100000000
   } state_type;

   cfg_type    cfg;
   dp_ctl_type ctl;
   dp_sts_type sts;

   state_type state_ff, state_in;
   logic [SAMPLE_WIDTH-1:0] sample_ff, sample_in;
   logic [HA_W-1:0]     wp_ff, wp_in;
   logic [FACTOR_W-1:0] opc_ff, opc_in;
   logic [L_W-1:0]      p_ff, p_in;
   logic [TAP_W-1:0]    tap_ff, tap_in;
   logic [HA_W-1:0]     idx_ff, idx_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [L_W-1:0]      rem_ff, rem_in;
   logic [LEN_W-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                fix_ff, fix_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic [PHASE_W-1:0]  rsp_phase_ff, rsp_phase_in;
   logic                rsp_last_ff, rsp_last_in;

   logic               accept;
   logic [L_W:0]       rem_sh;
   logic [DEPTH_W-1:0] depth_c;
   logic [HA_W-1:0]    wp_next, idx_step;
   logic               tap_live, out_free;
   logic [ACC_W-1:0]   rounded;
   logic [ACC_W-1:0]   clamped;

   rpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rpr_datapath u_dp (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .cfg   (cfg),
      .sts   (sts)
   );

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign accept         = req_ch.valid & req_ch.ready;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = rsp_sample_ff;
   assign rsp_ch.phase      = rsp_phase_ff;
   assign rsp_ch.last       = rsp_last_ff;

   always_comb begin
      rem_sh = {rem_ff, quo_ff[LEN_W-1]};
      if (quo_ff == '0)
         depth_c = DEPTH_W'(1);
      else if (32'(quo_ff) > HISTORY_DEPTH)
         depth_c = DEPTH_W'(HISTORY_DEPTH);
      else
         depth_c = DEPTH_W'(quo_ff);
      wp_next  = (32'(wp_ff) + 32'd1 >= 32'(depth_c)) ? '0 : wp_ff + HA_W'(1);
      idx_step = (idx_ff == '0) ? HA_W'(depth_ff - DEPTH_W'(1)) : idx_ff - HA_W'(1);
      tap_live = tap_ff < TAP_W'(cfg.len);
      out_free = !rsp_valid_ff || rsp_ch.ready;
      // round half up at the binary point, then saturate
      rounded  = ACC_W'($signed(sts.acc + ROUND_BIAS) >>> FRAC_BITS);
      if ($signed(rounded) > $signed(SAT_MAX))
         clamped = SAT_MAX;
      else if ($signed(rounded) < $signed(SAT_MIN))
         clamped = SAT_MIN;
      else
         clamped = rounded;
   end

   always_comb begin
      state_in      = state_ff;
      sample_in     = sample_ff;
      wp_in         = wp_ff;
      opc_in        = opc_ff;
      p_in          = p_ff;
      tap_in        = tap_ff;
      idx_in        = idx_ff;
      depth_in      = depth_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      fix_in        = fix_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_phase_in  = rsp_phase_ff;
      rsp_last_in   = rsp_last_ff;

      ctl              = '0;
      ctl.coef_waddr   = CA_W'(req_ch.coef_index);
      ctl.coef_wdata   = req_ch.coef_value;
      ctl.hist_waddr   = wp_next;
      ctl.hist_wdata   = sample_ff;
      ctl.rd_hist_addr = idx_ff;
      ctl.rd_coef_addr = tap_ff[CA_W-1:0];
      ctl.fix          = fix_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_ch.op)
                  OP_COEF: begin
                     ctl.coef_we = 32'(req_ch.coef_index) < COEF_DEPTH;
                  end
                  OP_CLEAR: begin
                     ctl.hist_clear = 1'b1;
                     wp_in          = '0;
                     opc_in         = cfg.decim;
                  end
                  OP_SAMPLE: begin
                     sample_in = req_ch.sample_in;
                     rem_in    = '0;
                     quo_in    = cfg.len;
                     cnt_in    = CNT_W'(LEN_W);
                     state_in  = ST_DIV;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            // restoring division step: history depth = length / L
            if (rem_sh >= {1'b0, cfg.interp}) begin
               rem_in = L_W'(rem_sh - {1'b0, cfg.interp});
               quo_in = {quo_ff[LEN_W-2:0], 1'b1};
            end else begin
               rem_in = L_W'(rem_sh);
               quo_in = {quo_ff[LEN_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1))
               state_in = ST_WRITE;
         end
         ST_WRITE: begin
            ctl.hist_we = 1'b1;
            wp_in       = wp_next;
            depth_in    = depth_c;
            p_in        = '0;
            state_in    = ST_PHASE;
         end
         ST_PHASE: begin
            if (p_ff == cfg.interp) begin
               state_in = ST_IDLE;
            end else if (opc_ff >= cfg.decim) begin
               opc_in         = FACTOR_W'(1);
               tap_in         = TAP_W'(p_ff);
               idx_in         = wp_ff;
               fix_in         = 1'b0;
               ctl.flag_clear = 1'b1;
               ctl.acc_clear  = 1'b1;
               state_in       = cfg.unwrap_en ? ST_SCAN : ST_MAC;
            end else begin
               opc_in = opc_ff + FACTOR_W'(1);
               p_in   = p_ff + L_W'(1);
            end
         end
         ST_SCAN: begin
            if (tap_live) begin
               ctl.rd_en = 1'b1;
               tap_in    = tap_ff + TAP_W'(cfg.interp);
               idx_in    = idx_step;
            end else begin
               state_in = ST_SCAN_WAIT;
            end
         end
         ST_SCAN_WAIT: begin
            if (!sts.busy) begin
               fix_in   = sts.lo & sts.hi;
               tap_in   = TAP_W'(p_ff);
               idx_in   = wp_ff;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (tap_live) begin
               ctl.rd_en  = 1'b1;
               ctl.rd_mac = 1'b1;
               tap_in     = tap_ff + TAP_W'(cfg.interp);
               idx_in     = idx_step;
            end else begin
               state_in = ST_MAC_WAIT;
            end
         end
         ST_MAC_WAIT: begin
            if (!sts.busy)
               state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = SAMPLE_WIDTH'(clamped);
               rsp_phase_in  = PHASE_W'(p_ff);
               // next result comes M sub-phases later, if still inside L
               rsp_last_in   = 32'(p_ff) + 32'(cfg.decim) >= 32'(cfg.interp);
               p_in          = p_ff + L_W'(1);
               state_in      = ST_PHASE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         opc_ff       <= DECIM_RESET;
         rsp_valid_ff <= 1'b0;
         p_ff         <= '0;
         cnt_ff       <= '0;
         fix_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         opc_ff       <= opc_in;
         rsp_valid_ff <= rsp_valid_in;
         p_ff         <= p_in;
         cnt_ff       <= cnt_in;
         fix_ff       <= fix_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff     <= sample_in;
      tap_ff        <= tap_in;
      idx_ff        <= idx_in;
      depth_ff      <= depth_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_phase_ff  <= rsp_phase_in;
      rsp_last_ff   <= rsp_last_in;
   end

   a_out_drained: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |-> !sts.busy)
      else $error("result taken while the MAC pipe still holds products");

   a_wp_in_depth: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PHASE |-> 32'(wp_ff) < 32'(depth_ff))
      else $error("write pointer outside the history depth");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PHASE |-> p_ff <= cfg.interp)
      else $error("sub-phase counter ran past L");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> (rsp_valid_ff && state_ff == ST_PHASE))
      else $error("result not loaded into the output register");

endmodule

`default_nettype wire

// ===== sim/polyphase_rational_resampler_tb.sv =====
// Self-checking testbench for polyphase_rational_resampler: a stimulus table, then
// random phases under several register settings, all checked by a predictor.
// Depends on rpr_pkg, rpr_if and the resampler RTL.
`default_nettype none

module polyphase_rational_resampler_tb;
   import rpr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 60;

   typedef struct {
      logic [SAMPLE_WIDTH-1:0] sample_out;
      logic [PHASE_W-1:0]      phase;
      logic                    last;
   } out_sample_type;

   typedef struct {
      logic [OP_W-1:0] op;
      int              idx;
      int              coef;
      int              smp;
      bit              typed;
      int              want;
   } stim_row_type;

   logic clock, reset;
   logic psel, penable, pwrite, pready;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata, prdata;

   rpr_req_if req_ch();
   rpr_rsp_if rsp_ch();

   polyphase_rational_resampler dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor state
   logic [FACTOR_W-1:0] cfg_l, cfg_m;
   logic [FLEN_W-1:0]   cfg_len;
   bit                  cfg_unwrap;
   longint              cfg_low, cfg_high, cfg_span;
   longint              hist_mem[HISTORY_DEPTH];
   int                  hist_wp, out_phase_cnt;
   longint              coef_mem[COEF_DEPTH];

   out_sample_type expected_q[$];
   int          errors;
   int          idle_pct;
   int          stall_cycles;

   stim_row_type directed_rows[14] = '{
      '{OP_COEF,   0,   16384,        0, 0,        0},
      '{OP_SAMPLE, 0,       0,  8388607, 1,  8388607},
      '{OP_SAMPLE, 0,       0, -8388608, 1, -8388608},
      '{OP_SAMPLE, 0,       0,        0, 1,        0},
      '{OP_COEF,   0, -524288,        0, 0,        0},
      '{OP_SAMPLE, 0,       0,  8388607, 1, -8388608},
      '{OP_SAMPLE, 0,       0, -8388608, 1,  8388607},
      '{OP_UNUSED, 255, 524287, -1,      0,        0},
      '{OP_COEF,   0,       1,        0, 0,        0},
      '{OP_SAMPLE, 0,       0,     8192, 0,        0},
      '{OP_SAMPLE, 0,       0,    -8193, 0,        0},
      '{OP_CLEAR,  0,       0,        0, 0,        0},
      '{OP_COEF,   255, 524287,       0, 0,        0},
      '{OP_SAMPLE, 0,       0,    12345, 0,        0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_interp();
      if (cfg_l == 0) return 1;
      if (cfg_l > MAX_INTERP) return MAX_INTERP;
      return cfg_l;
   endfunction

   function automatic int eff_decim();
      return (cfg_m == 0) ? 1 : cfg_m;
   endfunction

   function automatic int eff_taps();
      if (cfg_len == 0) return 1;
      if (cfg_len > COEF_DEPTH) return COEF_DEPTH;
      return cfg_len;
   endfunction

   function automatic int ring_depth();
      int d;
      d = eff_taps() / eff_interp();
      if (d == 0) d = 1;
      if (d > HISTORY_DEPTH) d = HISTORY_DEPTH;
      return d;
   endfunction

   function automatic longint ring_tap(int i, int d);
      return hist_mem[((hist_wp % d) + d - (i % d)) % d];
   endfunction

   function automatic logic [SAMPLE_WIDTH-1:0] filter_phase(int p);
      int     l, len, d, tap, i;
      bit     lo, hi, fix;
      longint acc, v, r;
      l = eff_interp(); len = eff_taps(); d = ring_depth();
      lo = 0; hi = 0; acc = 0;
      if (cfg_unwrap) begin
         for (tap = p, i = 0; tap < len; tap += l, i++) begin
            v = ring_tap(i, d);
            if (v > cfg_high) hi = 1;
            if (v < cfg_low) lo = 1;
         end
      end
      fix = lo && hi;
      for (tap = p, i = 0; tap < len; tap += l, i++) begin
         v = ring_tap(i, d);
         if (fix && v < cfg_low) v += cfg_span;
         acc += coef_mem[tap] * v;
      end
      r = (acc + 8192) >>> FRAC_BITS;
      if (r > 64'sd8388607) r = 64'sd8388607;
      if (r < -64'sd8388608) r = -64'sd8388608;
      return r[SAMPLE_WIDTH-1:0];
   endfunction

   function automatic void clear_history();
      foreach (hist_mem[k]) hist_mem[k] = 0;
      hist_wp = 0;
      out_phase_cnt = eff_decim();
   endfunction

   // advance the predictor by one accepted transaction
   function automatic void predict_outputs(logic [OP_W-1:0] op, logic [7:0] idx,
                                           logic [COEF_W-1:0] cv,
                                           logic [SAMPLE_WIDTH-1:0] smp);
      int          d, p, n;
      out_sample_type o;
      n = 0;
      case (op)
         OP_COEF:  coef_mem[idx] = longint'($signed(cv));
         OP_CLEAR: clear_history();
         OP_SAMPLE: begin
            d = ring_depth();
            hist_wp++;
            if (hist_wp >= d) hist_wp = 0;
            hist_mem[hist_wp] = longint'($signed(smp));
            for (p = 0; p < eff_interp(); p++) begin
               if (out_phase_cnt >= eff_decim()) begin
                  out_phase_cnt = 0;
                  o.sample_out = filter_phase(p);
                  o.phase = p[PHASE_W-1:0];
                  o.last = 1'b0;
                  expected_q.push_back(o);
                  n++;
               end
               out_phase_cnt++;
            end
            if (n > 0) expected_q[$].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic csr_write(logic [REG_IDX_W-1:0] ridx, int value);
      logic signed [BOUND_W-1:0] bound;
      bound = value[BOUND_W-1:0];
      case (ridx)
         REG_INTERP:      cfg_l = value[FACTOR_W-1:0];
         REG_DECIM:       cfg_m = value[FACTOR_W-1:0];
         REG_FLEN:        cfg_len = value[FLEN_W-1:0];
         REG_UNWRAP_EN:   cfg_unwrap = value[0];
         REG_UNWRAP_LOW:  cfg_low = bound;
         REG_UNWRAP_HIGH: cfg_high = bound;
         REG_UNWRAP_SPAN: cfg_span = value[SPAN_W-1:0];
         default: ;
      endcase
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= ADDR_W'(ridx * 4);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   task automatic send_txn(logic [OP_W-1:0] op, int idx, int cv, int smp);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 50);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.coef_index <= idx[7:0];
      req_ch.coef_value <= cv[COEF_W-1:0];
      req_ch.sample_in <= smp[SAMPLE_WIDTH-1:0];
      do @(posedge clock); while (!req_ch.ready);
      predict_outputs(op, idx[7:0], cv[COEF_W-1:0], smp[SAMPLE_WIDTH-1:0]);
   endtask

   // wait out results, then any result-free work still in flight
   task automatic drain_block();
      req_ch.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_txn();
      int r, v;
      r = $urandom_range(0, 99);
      v = $urandom();
      if (r < 82) send_txn(OP_SAMPLE, $urandom(), $urandom(), v);
      else if (r < 92) send_txn(OP_COEF, $urandom_range(0, 255), $urandom(), v);
      else if (r < 96) send_txn(OP_CLEAR, $urandom(), $urandom(), v);
      else send_txn(OP_UNUSED, $urandom(), $urandom(), v);
   endtask

   // response sink with random back-pressure
   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
   end

   always @(posedge clock) begin
      out_sample_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction out=%0h phase=%0d",
                                      rsp_ch.sample_out, rsp_ch.phase));
         end else begin
            e = expected_q.pop_front();
            if (rsp_ch.sample_out !== e.sample_out)
               report_mismatch($sformatf("sample_out %0h, want %0h (phase %0d)",
                                         rsp_ch.sample_out, e.sample_out, e.phase));
            if (rsp_ch.phase !== e.phase)
               report_mismatch($sformatf("phase %0d, want %0d", rsp_ch.phase, e.phase));
            if (rsp_ch.last !== e.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_ch.last, e.last));
         end
      end
   end

   // watchdog: cycles without any transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int k, ph, n, sel, lo;
      errors = 0; idle_pct = 8; stall_cycles = 0;
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req_ch.valid = 1'b0; req_ch.op = OP_SAMPLE; req_ch.coef_index = '0;
      req_ch.coef_value = '0; req_ch.sample_in = '0;
      cfg_l = 1; cfg_m = 1; cfg_len = 1; cfg_unwrap = 0;
      cfg_low = 0; cfg_high = 0; cfg_span = 0;
      foreach (coef_mem[i]) coef_mem[i] = 0;
      clear_history();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every coefficient gets written before any tap can read it
      for (k = 0; k < COEF_DEPTH; k++)
         send_txn(OP_COEF, k, (k == 1) ? -524288 : int'($urandom()), 0);

      foreach (directed_rows[i]) begin
         send_txn(directed_rows[i].op, directed_rows[i].idx,
                  directed_rows[i].coef, directed_rows[i].smp);
         if (directed_rows[i].typed)
            expected_q[$].sample_out = directed_rows[i].want[SAMPLE_WIDTH-1:0];
      end

      for (ph = 0; ph < 12; ph++) begin
         drain_block();
         idle_pct = (ph >= 3 && ph <= 5) ? 0 : 8;
         case (ph)
            0: begin
               csr_write(REG_INTERP, 15); csr_write(REG_DECIM, 0);
               csr_write(REG_FLEN, 511);
            end
            1: begin
               csr_write(REG_INTERP, 0); csr_write(REG_DECIM, 15);
               csr_write(REG_FLEN, 0);
            end
            2: begin
               csr_write(REG_INTERP, 8); csr_write(REG_DECIM, 1);
               csr_write(REG_FLEN, 256);
            end
            default: begin
               csr_write(REG_INTERP, $urandom_range(0, 15));
               csr_write(REG_DECIM, $urandom_range(0, 15));
               csr_write(REG_FLEN, ($urandom_range(0, 9) == 0) ?
                         $urandom_range(0, 511) : $urandom_range(0, 40));
            end
         endcase
         csr_write(REG_UNWRAP_EN, (ph == 0) ? 1 : ((ph == 1) ? 0 : $urandom_range(0, 1)));
         sel = $urandom_range(0, 3);
         lo = (sel == 0) ? -8388608 : -int'($urandom_range(0, 8388607));
         csr_write(REG_UNWRAP_LOW, (ph == 2) ? 8388607 : lo);
         csr_write(REG_UNWRAP_HIGH, (sel == 1) ? 8388607 :
                   (sel == 2) ? -8388608 : int'($urandom_range(0, 8388607)));
         csr_write(REG_UNWRAP_SPAN, (sel == 3) ? 8388607 : $urandom_range(0, 8388607));
         n = (eff_taps() > 64) ? 8 : 18;
         for (k = 0; k < n; k++) random_txn();
      end

      drain_block();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== polyphase_rational_resampler.f =====
rtl/core/rpr_pkg.sv
rtl/core/rpr_if.sv
rtl/core/rpr_csr.sv
rtl/core/rpr_datapath.sv
rtl/core/polyphase_rational_resampler.sv
sim/polyphase_rational_resampler_tb.sv
